@@ rtl/core/simon64_pkg.sv @@
// ----------------------------------------------------------------------------
// simon64_pkg
// shared constants, types and round functions for the simon 64 cipher block
// ----------------------------------------------------------------------------
package simon64_pkg;

    localparam int MAX_ROUNDS_DEF = 64;
    localparam int ZIDX_WRAP      = 61;
    localparam int KEY_BYTES      = 16;

    localparam logic [63:0] Z_SEQ [2] = '{
        64'h3369_F885_192C_0EF5,
        64'h3C2C_E512_07A6_35DB
    };

    typedef enum logic [1:0] {
        CFG_KEY_HIGH    = 2'd0,
        CFG_KEY_LOW     = 2'd1,
        CFG_KEY_LENGTH  = 2'd2,
        CFG_ROUND_COUNT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic busy;
        logic done;
    } t_ks_stat;

    typedef struct packed {
        logic start;
        logic func;
    } t_rnd_ctl;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int n);
        rotl32 = (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] rotr32(input logic [31:0] x, input int n);
        rotr32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] mix32(input logic [31:0] x);
        mix32 = (rotl32(x, 1) & rotl32(x, 8)) ^ rotl32(x, 2);
    endfunction

    // key lengths above sixteen bytes act as sixteen
    function automatic logic [4:0] eff_len(input logic [4:0] len);
        eff_len = (len > 5'd16) ? 5'd16 : len;
    endfunction

endpackage

@@ rtl/core/simon64_key_ram.sv @@
// ----------------------------------------------------------------------------
// simon64_key_ram
// round key store, one write port and one read port with registered data
// ----------------------------------------------------------------------------
module simon64_key_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/simon64_key_sched.sv @@
// ----------------------------------------------------------------------------
// simon64_key_sched
// key expansion, one round key per cycle written into the key store
// ----------------------------------------------------------------------------
module simon64_key_sched
    import simon64_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF,
    parameter int AW         = $clog2(MAX_ROUNDS),
    parameter int RW         = $clog2(MAX_ROUNDS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [63:0]   i_key_high,
    input  logic [63:0]   i_key_low,
    input  logic [4:0]    i_key_length,
    input  logic [RW-1:0] i_rounds,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [31:0]   o_wdata,
    output t_ks_stat      o_stat
);

    logic [4:0]    w_len;
    logic          w_m4;
    logic [127:0]  w_key;
    logic [31:0]   w_kw [4];
    logic [31:0]   w_gen;
    logic [31:0]   w_t;
    logic          w_init;

    logic          r_busy;
    logic          r_done;
    logic [RW-1:0] r_idx;
    logic [5:0]    r_zidx;
    logic [31:0]   r_win [4];

    // zero the key bytes past the key length
    always_comb begin
        w_len = eff_len(i_key_length);
        w_m4  = (w_len > 5'd12);
        w_key = {i_key_high, i_key_low};
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (5'(b) >= w_len) begin
                w_key[127 - 8 * b -: 8] = 8'h00;
            end
        end
        for (int j = 0; j < 4; j++) begin
            w_kw[j] = w_m4 ? w_key[32 * j +: 32] : w_key[32 * (j + 1) +: 32];
        end
    end

    always_comb begin
        w_t = rotr32(r_win[3], 3);
        if (w_m4) begin
            w_t = w_t ^ r_win[1];
        end
        w_gen  = w_t ^ rotr32(w_t, 1) ^ ~(w_m4 ? r_win[0] : r_win[1]) ^ 32'd3
                 ^ {31'd0, Z_SEQ[w_m4][r_zidx]};
        w_init = w_m4 ? (r_idx < RW'(4)) : (r_idx < RW'(3));
    end

    assign o_we        = r_busy;
    assign o_waddr     = r_idx[AW-1:0];
    assign o_wdata     = w_init ? w_kw[r_idx[1:0]] : w_gen;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
            r_zidx <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_idx == i_rounds - RW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_zidx <= '0;
            end else if (r_busy) begin
                r_idx <= r_idx + RW'(1);
                if (!w_init) begin
                    r_zidx <= (r_zidx == 6'(ZIDX_WRAP)) ? 6'd0 : r_zidx + 6'd1;
                end
                if (r_idx == i_rounds - RW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // sliding window of the last four keys written
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win[0] <= r_win[1];
            r_win[1] <= r_win[2];
            r_win[2] <= r_win[3];
            r_win[3] <= o_wdata;
        end
    end

endmodule

@@ rtl/core/simon64_round.sv @@
// ----------------------------------------------------------------------------
// simon64_round
// feistel round sequencer, one round per cycle with keys prefetched from the store
// ----------------------------------------------------------------------------
module simon64_round
    import simon64_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF,
    parameter int AW         = $clog2(MAX_ROUNDS),
    parameter int RW         = $clog2(MAX_ROUNDS + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_rnd_ctl      i_ctl,
    input  logic [63:0]   i_data,
    input  logic [RW-1:0] i_rounds,
    output logic          o_re,
    output logic [AW-1:0] o_raddr,
    input  logic [31:0]   i_rdata,
    output logic          o_done,
    output logic [63:0]   o_result
);

    logic          r_busy;
    logic          r_pend;
    logic          r_done;
    logic          r_func;
    logic [RW-1:0] r_issue;
    logic [RW-1:0] r_used;
    logic [31:0]   r_a;
    logic [31:0]   r_b;

    logic          w_upd_b;
    logic [31:0]   w_f;
    logic [RW-1:0] w_addr;

    always_comb begin
        o_re    = r_busy && (r_issue != i_rounds);
        w_addr  = r_func ? (i_rounds - RW'(1) - r_issue) : r_issue;
        o_raddr = w_addr[AW-1:0];
        w_upd_b = (r_used[0] == r_func);
        w_f     = mix32(w_upd_b ? r_a : r_b) ^ i_rdata;
    end

    assign o_done   = r_done;
    assign o_result = i_rounds[0] ? {r_b, r_a} : {r_a, r_b};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_issue <= '0;
            r_used  <= '0;
        end else begin
            r_done <= !i_ctl.start && r_pend && (r_used == i_rounds - RW'(1));
            r_pend <= !i_ctl.start && o_re;
            if (i_ctl.start) begin
                r_busy  <= 1'b1;
                r_issue <= '0;
                r_used  <= '0;
            end else begin
                if (o_re) begin
                    r_issue <= r_issue + RW'(1);
                end
                if (r_pend) begin
                    r_used <= r_used + RW'(1);
                    if (r_used == i_rounds - RW'(1)) begin
                        r_busy <= 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_func <= i_ctl.func;
            r_a    <= i_data[63:32];
            r_b    <= i_data[31:0];
        end else if (r_pend) begin
            if (w_upd_b) begin
                r_b <= r_b ^ w_f;
            end else begin
                r_a <= r_a ^ w_f;
            end
        end
    end

endmodule

@@ rtl/core/simon64_block_cipher.sv @@
// ----------------------------------------------------------------------------
// simon64_block_cipher
// simon 64 block cipher with 96/128 bit key schedule and a round key store
// ----------------------------------------------------------------------------
// usage
//   slave stream: tdata carries the 64-bit block, tuser the direction bit
//   (0 encrypt, 1 decrypt); one transaction per block.
//   master stream: tdata carries the 64-bit result, one transaction per block.
//   config port: write key_high, key_low, key_length, round_count by index.
//   a config write marks the round keys stale; the next block first runs the
//   key expansion, one key per cycle into the store.
// rounds
//   R rounds (default 36 + 2*ceil(len/4), at most MAX_ROUNDS), one round per
//   cycle, each round key read from the registered key store the cycle
//   before its round. one block is in flight at a time: a new block is
//   taken only once the last result has left the core.
// reset / stall
//   reset clears the registers to key_length 16 and marks keys stale.
//   the result register frees the core; a stalled receiver holds the next
//   finished block in the core and blocks new input until it is taken.
// ----------------------------------------------------------------------------
module simon64_block_cipher
    import simon64_pkg::*;
#(
    parameter int MAX_ROUNDS = MAX_ROUNDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // data_in
    input  logic        i_s_axis_tuser,   // func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // data_out
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    localparam int AW  = $clog2(MAX_ROUNDS);
    localparam int RW  = $clog2(MAX_ROUNDS + 1);
    localparam int RCW = (RW > 7) ? RW : 7;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EXPAND = 4'b0010,
        S_RUN    = 4'b0100,
        S_HOLD   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [63:0]   r_key_high;
    logic [63:0]   r_key_low;
    logic [4:0]    r_key_length;
    logic [6:0]    r_round_count;
    logic          r_keys_ready, n_keys_ready;
    logic          r_ks_start, n_ks_start;
    logic          r_rnd_start, n_rnd_start;
    logic          r_func;
    logic [63:0]   r_data;
    logic          r_out_valid, n_out_valid;
    logic [63:0]   r_out_data;

    logic          w_in_acc;
    logic          w_out_free;
    logic          w_load;
    logic [4:0]    w_len;
    logic [5:0]    w_dflt;
    logic [RCW-1:0] w_rsel;
    logic [RW-1:0] w_rounds;

    logic          ks_we;
    logic [AW-1:0] ks_waddr;
    logic [31:0]   ks_wdata;
    t_ks_stat      ks_stat;
    t_rnd_ctl      rnd_ctl;
    logic          rnd_re;
    logic [AW-1:0] rnd_raddr;
    logic [31:0]   ram_rdata;
    logic          rnd_done;
    logic [63:0]   rnd_result;

    always_comb begin
        w_len    = eff_len(r_key_length);
        w_dflt   = 6'd36 + {((w_len + 5'd3) >> 2), 1'b0};
        w_rsel   = (r_round_count == 7'd0) ? RCW'(w_dflt) : RCW'(r_round_count);
        w_rounds = (w_rsel > RCW'(MAX_ROUNDS)) ? RW'(MAX_ROUNDS) : w_rsel[RW-1:0];
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free      = !r_out_valid || i_m_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign rnd_ctl.start   = r_rnd_start;
    assign rnd_ctl.func    = r_func;

    always_comb begin
        n_state      = r_state;
        n_keys_ready = r_keys_ready;
        n_ks_start   = 1'b0;
        n_rnd_start  = 1'b0;
        w_load       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (r_keys_ready) begin
                        n_rnd_start = 1'b1;
                        n_state     = S_RUN;
                    end else begin
                        n_ks_start = 1'b1;
                        n_state    = S_EXPAND;
                    end
                end
            end
            S_EXPAND: begin
                if (ks_stat.done) begin
                    n_keys_ready = 1'b1;
                    n_rnd_start  = 1'b1;
                    n_state      = S_RUN;
                end
            end
            S_RUN: begin
                if (rnd_done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (i_cfg_we) begin
            n_keys_ready = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_keys_ready  <= 1'b0;
            r_ks_start    <= 1'b0;
            r_rnd_start   <= 1'b0;
            r_out_valid   <= 1'b0;
            r_key_high    <= '0;
            r_key_low     <= '0;
            r_key_length  <= 5'd16;
            r_round_count <= '0;
        end else begin
            r_state      <= n_state;
            r_keys_ready <= n_keys_ready;
            r_ks_start   <= n_ks_start;
            r_rnd_start  <= n_rnd_start;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY_HIGH:    r_key_high    <= i_cfg_data;
                    CFG_KEY_LOW:     r_key_low     <= i_cfg_data;
                    CFG_KEY_LENGTH:  r_key_length  <= i_cfg_data[4:0];
                    CFG_ROUND_COUNT: r_round_count <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_func <= i_s_axis_tuser;
            r_data <= i_s_axis_tdata;
        end
        if (w_load) begin
            r_out_data <= rnd_result;
        end
    end

    simon64_key_sched #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .AW         (AW),
        .RW         (RW)
    ) u_key_sched (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (r_ks_start),
        .i_key_high   (r_key_high),
        .i_key_low    (r_key_low),
        .i_key_length (r_key_length),
        .i_rounds     (w_rounds),
        .o_we         (ks_we),
        .o_waddr      (ks_waddr),
        .o_wdata      (ks_wdata),
        .o_stat       (ks_stat)
    );

    simon64_key_ram #(
        .DEPTH (MAX_ROUNDS),
        .AW    (AW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ks_we),
        .i_waddr (ks_waddr),
        .i_wdata (ks_wdata),
        .i_re    (rnd_re),
        .i_raddr (rnd_raddr),
        .o_rdata (ram_rdata)
    );

    simon64_round #(
        .MAX_ROUNDS (MAX_ROUNDS),
        .AW         (AW),
        .RW         (RW)
    ) u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rnd_ctl),
        .i_data   (r_data),
        .i_rounds (w_rounds),
        .o_re     (rnd_re),
        .o_raddr  (rnd_raddr),
        .i_rdata  (ram_rdata),
        .o_done   (rnd_done),
        .o_result (rnd_result)
    );

    a_ks_in_expand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ks_stat.busy |-> (r_state == S_EXPAND))
        else $error("key expansion active outside expand state");

    a_store_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ks_we && rnd_re))
        else $error("key store written and read in the same cycle");

    a_run_keys_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_keys_ready)
        else $error("rounds running on stale keys");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rnd_done |-> (r_state == S_RUN))
        else $error("round completion outside run state");

endmodule

@@ tb/tb_simon64_block_cipher.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_simon64_block_cipher
// self-checking stream testbench for the simon 64 block cipher
// ----------------------------------------------------------------------------
// a clocked driver feeds blocks from a queue that the stimulus process fills,
// a clocked monitor takes results and compares them against a local cipher
// model that keeps its own copy of the key registers and key schedule.
// key settings change only while the block is drained. a directed part covers
// reset keys, short and long key lengths, odd and saturated round counts;
// random phases follow with random keys, random gaps on both streams and a
// long receiver hold-off that backs the cipher up.
// ----------------------------------------------------------------------------
module tb_simon64_block_cipher;
    import simon64_pkg::*;

    localparam int SCHED_DEPTH    = MAX_ROUNDS_DEF;
    localparam int RANDOM_ITEMS   = 1230;
    localparam int LONG_HOLD      = 500;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * SCHED_DEPTH + 8;

    typedef struct packed {
        logic        func;
        logic [63:0] block;
    } t_blk_req;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [63:0] i_s_axis_tdata  = '0;   // data_in
    logic        i_s_axis_tuser  = 1'b0; // func
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;         // data_out
    logic        i_cfg_we        = 1'b0;
    logic [1:0]  i_cfg_idx       = '0;
    logic [63:0] i_cfg_data      = '0;

    simon64_block_cipher i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    // local copy of the key registers and the expanded schedule
    logic [63:0] key_hi_copy    = '0;
    logic [63:0] key_lo_copy    = '0;
    logic [4:0]  key_len_copy   = 5'd16;
    logic [6:0]  rounds_copy    = '0;
    logic [31:0] sched [SCHED_DEPTH];
    bit          sched_valid    = 1'b0;

    t_blk_req    pending_blocks [$];
    logic [63:0] expected_out [$];
    t_blk_req    cur_req;

    bit idle_en      = 1'b1;
    int send_gap     = 0;
    int rx_gap       = 0;
    int hold_req     = 0;
    int hold_served  = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int random_sent  = 0;
    int phase_no     = 0;
    int n_blocks     = 0;
    int pick;
    logic [63:0] kh_rand, kl_rand;
    logic [4:0]  len_rand;
    logic [6:0]  rc_rand;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rot_left(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] round_fn(input logic [31:0] x);
        return (rot_left(x, 1) & rot_left(x, 8)) ^ rot_left(x, 2);
    endfunction

    function automatic int used_key_bytes();
        return (key_len_copy > 5'd16) ? 16 : int'(key_len_copy);
    endfunction

    function automatic int rounds_to_run();
        int nr;
        nr = int'(rounds_copy);
        if (nr == 0)
            nr = 36 + (((used_key_bytes() + 3) >> 2) << 1);
        if (nr > SCHED_DEPTH)
            nr = SCHED_DEPTH;
        return nr;
    endfunction

    function automatic void expand_schedule();
        int klen, nr, nw, i;
        logic [31:0] t;
        logic [7:0] kbyte;
        klen = used_key_bytes();
        nr = rounds_to_run();
        nw = (klen + 3) >> 2;
        if (nw < 3)
            nw = 3;
        for (i = 0; i < nw; i++)
            sched[i] = '0;
        for (i = 0; i < klen; i++) begin
            if (i < 8)
                kbyte = key_hi_copy[63 - 8 * i -: 8];
            else
                kbyte = key_lo_copy[63 - 8 * (i - 8) -: 8];
            sched[nw - 1 - (i >> 2)] |= {24'd0, kbyte} << (24 - 8 * (i & 3));
        end
        for (i = nw; i < nr; i++) begin
            t = rot_right(sched[i - 1], 3);
            if (nw == 4)
                t ^= sched[i - 3];
            t ^= rot_right(t, 1) ^ ~sched[i - nw] ^ 32'd3;
            sched[i] = t ^ {31'd0, Z_SEQ[nw - 3][(i - nw) % 62]};
        end
        sched_valid = 1'b1;
    endfunction

    function automatic logic [63:0] simon_crypt(input logic func, input logic [63:0] din);
        int nr, i;
        logic [31:0] a, b;
        if (!sched_valid)
            expand_schedule();
        nr = rounds_to_run();
        a = din[63:32];
        b = din[31:0];
        if (!func) begin
            i = 0;
            while (i < nr) begin
                b ^= round_fn(a) ^ sched[i];
                i++;
                if (i == nr)
                    break;
                a ^= round_fn(b) ^ sched[i];
                i++;
            end
        end else begin
            i = nr;
            while (i > 0) begin
                i--;
                a ^= round_fn(b) ^ sched[i];
                if (i == 0)
                    break;
                i--;
                b ^= round_fn(a) ^ sched[i];
            end
        end
        return (nr % 2 == 1) ? {b, a} : {a, b};
    endfunction

    function automatic void mirror_cfg(input t_cfg_idx idx, input logic [63:0] value);
        case (idx)
            CFG_KEY_HIGH:    key_hi_copy = value;
            CFG_KEY_LOW:     key_lo_copy = value;
            CFG_KEY_LENGTH:  key_len_copy = value[4:0];
            CFG_ROUND_COUNT: rounds_copy = value[6:0];
            default: ;
        endcase
        sched_valid = 1'b0;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 20);
        return $urandom_range(40, 120);
    endfunction

    function automatic logic [63:0] corner_block(input int k);
        case (k % 6)
            0: return 64'h0;
            1: return '1;
            2: return 64'h8000_0000_0000_0001;
            3: return 64'h5555_5555_5555_5555;
            4: return 64'hAAAA_AAAA_AAAA_AAAA;
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_out.push_back(simon_crypt(cur_req.func, cur_req.block));
                send_gap = pick_gap();
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_blocks.size() != 0) begin
                    cur_req = pending_blocks.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= cur_req.block;
                    i_s_axis_tuser  <= cur_req.func;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            rx_gap = 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_out.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result %h", o_m_axis_tdata);
                    mismatches++;
                end else if (expected_out[0] !== o_m_axis_tdata) begin
                    if (mismatches < 10)
                        $display("data_out mismatch: expected %h actual %h",
                                 expected_out[0], o_m_axis_tdata);
                    mismatches++;
                    void'(expected_out.pop_front());
                end else begin
                    void'(expected_out.pop_front());
                end
                rx_gap = pick_gap();
            end
            if (rx_gap > 0) begin
                rx_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= (hold_left == 0);
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_req != hold_served) begin
            hold_left   <= LONG_HOLD;
            hold_served <= hold_req;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL simon64_block_cipher");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (pending_blocks.size() != 0 || i_s_axis_tvalid || expected_out.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input t_cfg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        mirror_cfg(idx, value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input logic [63:0] kh, input logic [63:0] kl,
                                 input logic [4:0] len, input logic [6:0] rc);
        wait_drained();
        cfg_write(CFG_KEY_HIGH, kh);
        cfg_write(CFG_KEY_LOW, kl);
        cfg_write(CFG_KEY_LENGTH, {59'd0, len});
        cfg_write(CFG_ROUND_COUNT, {57'd0, rc});
    endtask

    task automatic queue_blocks(input int n, input bit directed);
        t_blk_req req;
        int j;
        @(negedge i_clk);
        for (j = 0; j < n; j++) begin
            if (directed) begin
                req.func  = j[0];
                req.block = corner_block(j >> 1);
            end else begin
                req.func  = $urandom_range(0, 1);
                if ($urandom_range(0, 9) == 0)
                    req.block = corner_block($urandom_range(0, 4));
                else
                    req.block = {$urandom(), $urandom()};
            end
            pending_blocks.push_back(req);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset key state, schedule built on the first block
        queue_blocks(5, 1'b1);
        // empty key, default rounds
        apply_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 5'd0, 7'd0);
        queue_blocks(2, 1'b1);
        // three key words at twelve bytes
        apply_setting('1, '1, 5'd12, 7'd0);
        queue_blocks(2, 1'b1);
        // key length above sixteen, round count above the store depth
        apply_setting(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 5'd31, 7'd127);
        queue_blocks(2, 1'b1);
        // four key words, full depth
        apply_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 5'd13, 7'd64);
        queue_blocks(2, 1'b1);
        // single round, halves swapped
        apply_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 5'd16, 7'd1);
        queue_blocks(2, 1'b1);
        // short key, odd round count
        apply_setting({$urandom(), $urandom()}, '0, 5'd5, 7'd3);
        queue_blocks(2, 1'b1);
        apply_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 5'd16, 7'd65);
        queue_blocks(2, 1'b1);
        apply_setting({$urandom(), $urandom()}, {$urandom(), $urandom()}, 5'd8, 7'd2);
        queue_blocks(2, 1'b1);

        while (random_sent < RANDOM_ITEMS) begin
            n_blocks = $urandom_range(20, 80);
            kh_rand = ($urandom_range(0, 9) == 0) ? 64'h0 : {$urandom(), $urandom()};
            kl_rand = ($urandom_range(0, 9) == 0) ? 64'h0 : {$urandom(), $urandom()};
            pick = $urandom_range(0, 99);
            len_rand = (pick < 15) ? 5'($urandom_range(17, 31)) : 5'($urandom_range(0, 16));
            pick = $urandom_range(0, 99);
            if (pick < 40)
                rc_rand = 7'd0;
            else if (pick < 50)
                rc_rand = 7'($urandom_range(65, 127));
            else
                rc_rand = 7'($urandom_range(1, 64));
            apply_setting(kh_rand, kl_rand, len_rand, rc_rand);
            @(negedge i_clk);
            idle_en = ($urandom_range(0, 4) != 0);
            if (phase_no == 2 || phase_no == 11)
                hold_req++;
            queue_blocks(n_blocks, 1'b0);
            random_sent += n_blocks;
            phase_no++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && expected_out.size() == 0)
            $display("PASS simon64_block_cipher");
        else
            $display("FAIL simon64_block_cipher");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/simon64_pkg.sv
rtl/core/simon64_key_ram.sv
rtl/core/simon64_key_sched.sv
rtl/core/simon64_round.sv
rtl/core/simon64_block_cipher.sv
tb/tb_simon64_block_cipher.sv
